// File: rtl/cglf_pkg.sv
// Package for the color gated line follower: shared types, codes and constants.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package cglf_pkg;

    localparam int PULSE_BITS = 20;
    // Compare width: holds any pulse width or 16-bit limit plus one carry bit.
    localparam int CMP_W = ((PULSE_BITS > 16) ? PULSE_BITS : 16) + 1;

    localparam logic [7:0] RIGHT_OFFSET = 8'd40;

    typedef logic [PULSE_BITS-1:0] pulse_t;

    typedef enum logic [2:0] {
        ST_WHITE     = 3'd0,
        ST_GREEN     = 3'd1,
        ST_STOP_BEGN = 3'd2,
        ST_RED       = 3'd3,
        ST_UNKNOWN   = 3'd4,
        ST_STOPPED   = 3'd5,
        ST_RESUMING  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        CFG_STRAIGHT_SPEED = 3'd0,
        CFG_TURN_SPEED     = 3'd1,
        CFG_WHITE_LIMIT    = 3'd2,
        CFG_GREEN_MARGIN   = 3'd3,
        CFG_RED_LIMIT      = 3'd4,
        CFG_RED_RUNS       = 3'd5,
        CFG_STOP_MS        = 3'd6,
        CFG_RESUME_MS      = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]  straight_speed;
        logic [7:0]  turn_speed;
        logic [15:0] white_limit;
        logic [15:0] green_margin;
        logic [15:0] red_limit;
        logic [2:0]  red_runs_needed;
        logic [15:0] stop_ms;
        logic [15:0] resume_ms;
    } cfg_t;

    typedef struct packed {
        logic is_white;
        logic is_green;
        logic is_red;
    } color_t;

    typedef struct packed {
        logic [7:0] left_forward;
        logic [7:0] left_reverse;
        logic [7:0] right_forward;
        logic [7:0] right_reverse;
    } drive_t;

    typedef struct packed {
        drive_t  drive;
        status_t status;
    } result_t;

endpackage

// File: rtl/cglf_classify.sv
// Color classifier: white / green / red flags from the three pulse widths.
// Depends on cglf_pkg.
module cglf_classify
(
    input  cglf_pkg::pulse_t red_width,
    input  cglf_pkg::pulse_t green_width,
    input  cglf_pkg::pulse_t blue_width,
    input  cglf_pkg::cfg_t   cfg,
    output cglf_pkg::color_t color
);

    logic [cglf_pkg::CMP_W-1:0] r;
    logic [cglf_pkg::CMP_W-1:0] g;
    logic [cglf_pkg::CMP_W-1:0] b;
    logic [cglf_pkg::CMP_W-1:0] wl;
    logic [cglf_pkg::CMP_W-1:0] gm;
    logic [cglf_pkg::CMP_W-1:0] rl;

    assign r  = cglf_pkg::CMP_W'(red_width);
    assign g  = cglf_pkg::CMP_W'(green_width);
    assign b  = cglf_pkg::CMP_W'(blue_width);
    assign wl = cglf_pkg::CMP_W'(cfg.white_limit);
    assign gm = cglf_pkg::CMP_W'(cfg.green_margin);
    assign rl = cglf_pkg::CMP_W'(cfg.red_limit);

    assign color.is_white = (r <= wl) && (g <= wl) && (b <= wl);
    // one spare bit in CMP_W keeps green + margin from wrapping
    assign color.is_green = (g < r) && (b <= g + gm);
    assign color.is_red   = (r < b) && (r <= g) && (r < rl);

endmodule

// File: rtl/cglf_steer.sv
// Steering table: four drive levels from the line-sensor bits.
// Depends on cglf_pkg.
module cglf_steer
(
    input  logic [3:0]       line_bits,
    input  cglf_pkg::cfg_t   cfg,
    output cglf_pkg::drive_t drive
);

    logic [7:0] straight;
    logic [7:0] turn;

    assign straight = cfg.straight_speed;
    assign turn     = cfg.turn_speed;

    always_comb
    begin
        drive = '0;
        if (line_bits[2] && line_bits[3])
        begin
            drive.left_reverse  = turn;
            drive.right_forward = turn;
        end
        else if (line_bits[0] || line_bits[1])
        begin
            drive.left_forward  = turn;
            drive.right_reverse = turn;
        end
        else if (line_bits[2])
        begin
            drive.left_reverse  = turn;
            drive.right_forward = turn;
        end
        else
        begin
            drive.left_forward = straight;
            // below the offset the right motor runs backward
            if (straight > cglf_pkg::RIGHT_OFFSET)
                drive.right_forward = straight - cglf_pkg::RIGHT_OFFSET;
            else
                drive.right_reverse = cglf_pkg::RIGHT_OFFSET - straight;
        end
    end

endmodule

// File: rtl/cglf_ctrl.sv
// Phase control: stop / resume timers, red-run counter, moving flag, held drives.
// Depends on cglf_pkg, cglf_classify and cglf_steer.
module cglf_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  cglf_pkg::cfg_t    cfg,
    input  cglf_pkg::pulse_t  red_width,
    input  cglf_pkg::pulse_t  green_width,
    input  cglf_pkg::pulse_t  blue_width,
    input  logic [3:0]        line_bits,
    input  logic [31:0]       now_ms,
    output cglf_pkg::result_t result
);

    cglf_pkg::color_t color;
    cglf_pkg::drive_t steer_drive;

    logic             stop_active_reg, stop_active_next;
    logic [31:0]      stop_start_reg, stop_start_next;
    logic             resume_active_reg, resume_active_next;
    logic [31:0]      resume_start_reg, resume_start_next;
    logic             moving_reg, moving_next;
    logic [2:0]       red_run_reg, red_run_next;
    cglf_pkg::drive_t drive_reg, drive_next;
    cglf_pkg::status_t status;

    cglf_classify u_classify
    (
        .red_width   (red_width),
        .green_width (green_width),
        .blue_width  (blue_width),
        .cfg         (cfg),
        .color       (color)
    );

    cglf_steer u_steer
    (
        .line_bits (line_bits),
        .cfg       (cfg),
        .drive     (steer_drive)
    );

    always_comb
    begin
        logic        res_act;
        logic [31:0] res_start;
        logic [2:0]  run;
        logic [2:0]  run_inc;

        stop_active_next   = stop_active_reg;
        stop_start_next    = stop_start_reg;
        resume_active_next = resume_active_reg;
        resume_start_next  = resume_start_reg;
        moving_next        = moving_reg;
        red_run_next       = red_run_reg;
        drive_next         = drive_reg;
        status             = cglf_pkg::ST_UNKNOWN;

        res_act   = resume_active_reg;
        res_start = resume_start_reg;
        run       = red_run_reg;
        run_inc   = (red_run_reg == 3'd7) ? 3'd7 : red_run_reg + 3'd1;

        if (stop_active_reg && ((now_ms - stop_start_reg) < {16'd0, cfg.stop_ms}))
        begin
            drive_next = '0;
            status     = cglf_pkg::ST_STOPPED;
        end
        else
        begin
            if (stop_active_reg)
            begin
                stop_active_next = 1'b0;
                run              = 3'd0;
                res_act          = 1'b1;
                res_start        = now_ms;
                run_inc          = 3'd1;
            end
            resume_start_next = res_start;
            red_run_next      = run;
            if (res_act && ((now_ms - res_start) < {16'd0, cfg.resume_ms}))
            begin
                resume_active_next = 1'b1;
                drive_next         = steer_drive;
                status             = cglf_pkg::ST_RESUMING;
            end
            else
            begin
                resume_active_next = 1'b0;
                if (color.is_white)
                begin
                    if (moving_reg)
                        drive_next = steer_drive;
                    status = cglf_pkg::ST_WHITE;
                end
                else if (color.is_green)
                begin
                    moving_next  = 1'b1;
                    red_run_next = 3'd0;
                    drive_next   = steer_drive;
                    status       = cglf_pkg::ST_GREEN;
                end
                else if (color.is_red)
                begin
                    if (run_inc >= cfg.red_runs_needed)
                    begin
                        drive_next       = '0;
                        stop_active_next = 1'b1;
                        stop_start_next  = now_ms;
                        moving_next      = 1'b0;
                        red_run_next     = 3'd0;
                        status           = cglf_pkg::ST_STOP_BEGN;
                    end
                    else
                    begin
                        red_run_next = run_inc;
                        if (moving_reg)
                            drive_next = steer_drive;
                        status = cglf_pkg::ST_RED;
                    end
                end
                else
                begin
                    if (moving_reg)
                        drive_next = steer_drive;
                    red_run_next = 3'd0;
                    status       = cglf_pkg::ST_UNKNOWN;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_active_reg   <= 1'b0;
            stop_start_reg    <= '0;
            resume_active_reg <= 1'b0;
            resume_start_reg  <= '0;
            moving_reg        <= 1'b0;
            red_run_reg       <= '0;
            drive_reg         <= '0;
        end
        else if (step)
        begin
            stop_active_reg   <= stop_active_next;
            stop_start_reg    <= stop_start_next;
            resume_active_reg <= resume_active_next;
            resume_start_reg  <= resume_start_next;
            moving_reg        <= moving_next;
            red_run_reg       <= red_run_next;
            drive_reg         <= drive_next;
        end
    end

    assign result.drive  = drive_next;
    assign result.status = status;

endmodule

// File: rtl/color_gated_line_follower_unit.sv
// Top level of the color gated line follower: config registers, input and result stages.
// Depends on cglf_pkg and cglf_ctrl.

// One word in, one word out. A word is taken into the input register, classified
// and stepped through the phase logic once the result stage is free, and lands in the
// result register at the end of that cycle. The unit sustains one word per cycle while
// out_ready stays high; a stall on the result side holds both stages. in_ready stays
// high while the input register is empty or the result stage can move. Configuration
// writes are always ready and take effect on the next word processed.
module color_gated_line_follower_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [cglf_pkg::PULSE_BITS-1:0] red_width,
    input  logic [cglf_pkg::PULSE_BITS-1:0] green_width,
    input  logic [cglf_pkg::PULSE_BITS-1:0] blue_width,
    input  logic [3:0]  line_bits,
    input  logic [31:0] now_ms,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  left_forward,
    output logic [7:0]  left_reverse,
    output logic [7:0]  right_forward,
    output logic [7:0]  right_reverse,
    output logic [2:0]  status
);

    cglf_pkg::cfg_t    cfg_reg;
    cglf_pkg::result_t result;
    cglf_pkg::result_t result_reg;

    logic             in_valid_reg;
    cglf_pkg::pulse_t red_reg, green_reg, blue_reg;
    logic [3:0]       bits_reg;
    logic [31:0]      now_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.straight_speed  <= 8'd160;
            cfg_reg.turn_speed      <= 8'd150;
            cfg_reg.white_limit     <= 16'd25;
            cfg_reg.green_margin    <= 16'd35;
            cfg_reg.red_limit       <= 16'd35;
            cfg_reg.red_runs_needed <= 3'd3;
            cfg_reg.stop_ms         <= 16'd5000;
            cfg_reg.resume_ms       <= 16'd3000;
        end
        else if (cfg_valid)
        begin
            case (cglf_pkg::cfg_index_t'(cfg_index))
                cglf_pkg::CFG_STRAIGHT_SPEED: cfg_reg.straight_speed  <= cfg_data[7:0];
                cglf_pkg::CFG_TURN_SPEED:     cfg_reg.turn_speed      <= cfg_data[7:0];
                cglf_pkg::CFG_WHITE_LIMIT:    cfg_reg.white_limit     <= cfg_data;
                cglf_pkg::CFG_GREEN_MARGIN:   cfg_reg.green_margin    <= cfg_data;
                cglf_pkg::CFG_RED_LIMIT:      cfg_reg.red_limit       <= cfg_data;
                cglf_pkg::CFG_RED_RUNS:       cfg_reg.red_runs_needed <= cfg_data[2:0];
                cglf_pkg::CFG_STOP_MS:        cfg_reg.stop_ms         <= cfg_data;
                cglf_pkg::CFG_RESUME_MS:      cfg_reg.resume_ms       <= cfg_data;
                default: ;
            endcase
        end
    end

    // result stage frees up when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            red_reg   <= red_width;
            green_reg <= green_width;
            blue_reg  <= blue_width;
            bits_reg  <= line_bits;
            now_reg   <= now_ms;
        end
        if (advance)
            result_reg <= result;
    end

    cglf_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .cfg         (cfg_reg),
        .red_width   (red_reg),
        .green_width (green_reg),
        .blue_width  (blue_reg),
        .line_bits   (bits_reg),
        .now_ms      (now_reg),
        .result      (result)
    );

    assign out_valid     = out_valid_reg;
    assign left_forward  = result_reg.drive.left_forward;
    assign left_reverse  = result_reg.drive.left_reverse;
    assign right_forward = result_reg.drive.right_forward;
    assign right_reverse = result_reg.drive.right_reverse;
    assign status        = result_reg.status;

endmodule

// File: rtl/cglf_checker.sv
// Port-level checker for color_gated_line_follower_unit, attached by bind.
// Depends on cglf_pkg.
module cglf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] left_forward,
    input logic [7:0] left_reverse,
    input logic [7:0] right_forward,
    input logic [7:0] right_reverse,
    input logic [2:0] status
);

    // stop phases command all drives to zero
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == cglf_pkg::ST_STOPPED || status == cglf_pkg::ST_STOP_BEGN)
        |-> (left_forward == 8'd0 && left_reverse == 8'd0 &&
             right_forward == 8'd0 && right_reverse == 8'd0))
        else $error("drive nonzero during stop");

    a_left_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_forward == 8'd0 || left_reverse == 8'd0))
        else $error("left motor driven both ways");

    a_right_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (right_forward == 8'd0 || right_reverse == 8'd0))
        else $error("right motor driven both ways");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
            $stable(left_forward) && $stable(right_forward))
        else $error("stalled output word changed");

endmodule

bind color_gated_line_follower_unit cglf_checker u_cglf_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .left_forward  (left_forward),
    .left_reverse  (left_reverse),
    .right_forward (right_forward),
    .right_reverse (right_reverse),
    .status        (status)
);

// File: tb/sv/cglf_follow_checker.sv
// Result checker for color_gated_line_follower_unit: tracks settings writes, predicts
// one drive/status word per accepted sensor word, compares the result words in order.
// Depends on cglf_pkg only.
module cglf_follow_checker
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data,

    input  logic             in_valid,
    input  logic             in_ready,
    input  cglf_pkg::pulse_t red_width,
    input  cglf_pkg::pulse_t green_width,
    input  cglf_pkg::pulse_t blue_width,
    input  logic [3:0]       line_bits,
    input  logic [31:0]      now_ms,

    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [7:0]       left_forward,
    input  logic [7:0]       left_reverse,
    input  logic [7:0]       right_forward,
    input  logic [7:0]       right_reverse,
    input  logic [2:0]       status,

    output int               mismatch_count,
    output int               pending_words,
    output int               words_checked
);
    import cglf_pkg::*;

    localparam int REPORT_LIMIT = 10;
    // straight, turn, white limit, green margin, red limit, runs, stop ms, resume ms
    localparam cfg_t POWER_UP = {8'd160, 8'd150, 16'd25, 16'd35, 16'd35, 3'd3,
                                 16'd5000, 16'd3000};

    cfg_t        settings;
    logic        halt_on;
    logic        resume_on;
    logic        moving;
    logic [31:0] halt_t0;
    logic [31:0] resume_t0;
    logic [2:0]  red_streak;
    drive_t      held;
    result_t     expected_words[$];

    function automatic drive_t motor_levels(input int left, input int right);
        drive_t d;
        int     mag_l;
        int     mag_r;
        mag_l = -left;
        mag_r = -right;
        d.left_forward  = (left > 0)  ? left[7:0]  : 8'd0;
        d.left_reverse  = (left > 0)  ? 8'd0       : mag_l[7:0];
        d.right_forward = (right > 0) ? right[7:0] : 8'd0;
        d.right_reverse = (right > 0) ? 8'd0       : mag_r[7:0];
        return d;
    endfunction

    function automatic drive_t steering(input logic [3:0] bits);
        int t;
        int s;
        t = int'(settings.turn_speed);
        s = int'(settings.straight_speed);
        if (bits[2] && bits[3])
            return motor_levels(-t, t);
        if (bits[0] || bits[1])
            return motor_levels(t, -t);
        if (bits[2])
            return motor_levels(-t, t);
        // right side may go negative when straight speed is under the offset
        return motor_levels(s, s - int'(RIGHT_OFFSET));
    endfunction

    task automatic follow_step(
        input  pulse_t      r_w,
        input  pulse_t      g_w,
        input  pulse_t      b_w,
        input  logic [3:0]  bits,
        input  logic [31:0] now,
        output result_t     res
    );
        int unsigned rv;
        int unsigned gv;
        int unsigned bv;
        logic [31:0] elapsed;
        logic        settled;
        status_t     code;
        rv = r_w;
        gv = g_w;
        bv = b_w;
        settled = 1'b0;
        code = ST_WHITE;

        if (halt_on) begin
            elapsed = now - halt_t0;
            if (elapsed < {16'd0, settings.stop_ms}) begin
                held = '0;
                code = ST_STOPPED;
                settled = 1'b1;
            end
            else begin
                halt_on = 1'b0;
                red_streak = '0;
                resume_on = 1'b1;
                resume_t0 = now;
            end
        end

        if (!settled && resume_on) begin
            elapsed = now - resume_t0;
            if (elapsed < {16'd0, settings.resume_ms}) begin
                held = steering(bits);
                code = ST_RESUMING;
                settled = 1'b1;
            end
            else begin
                resume_on = 1'b0;
            end
        end

        if (!settled) begin
            if (rv <= settings.white_limit && gv <= settings.white_limit &&
                bv <= settings.white_limit) begin
                if (moving)
                    held = steering(bits);
                code = ST_WHITE;
            end
            else if (gv < rv && bv <= gv + settings.green_margin) begin
                moving = 1'b1;
                red_streak = '0;
                held = steering(bits);
                code = ST_GREEN;
            end
            else if (rv < bv && rv <= gv && rv < settings.red_limit) begin
                if (red_streak != 3'd7)
                    red_streak = red_streak + 3'd1;
                if (red_streak >= settings.red_runs_needed) begin
                    held = '0;
                    halt_on = 1'b1;
                    halt_t0 = now;
                    moving = 1'b0;
                    red_streak = '0;
                    code = ST_STOP_BEGN;
                end
                else begin
                    if (moving)
                        held = steering(bits);
                    code = ST_RED;
                end
            end
            else begin
                if (moving)
                    held = steering(bits);
                red_streak = '0;
                code = ST_UNKNOWN;
            end
        end

        res.drive = held;
        res.status = code;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n) begin
            settings = POWER_UP;
            halt_on = 1'b0;
            resume_on = 1'b0;
            moving = 1'b0;
            halt_t0 = '0;
            resume_t0 = '0;
            red_streak = '0;
            held = '0;
            expected_words.delete();
            pending_words = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    CFG_STRAIGHT_SPEED: settings.straight_speed  = cfg_data[7:0];
                    CFG_TURN_SPEED:     settings.turn_speed      = cfg_data[7:0];
                    CFG_WHITE_LIMIT:    settings.white_limit     = cfg_data;
                    CFG_GREEN_MARGIN:   settings.green_margin    = cfg_data;
                    CFG_RED_LIMIT:      settings.red_limit       = cfg_data;
                    CFG_RED_RUNS:       settings.red_runs_needed = cfg_data[2:0];
                    CFG_STOP_MS:        settings.stop_ms         = cfg_data;
                    CFG_RESUME_MS:      settings.resume_ms       = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && in_ready) begin
                follow_step(red_width, green_width, blue_width, line_bits, now_ms, want);
                expected_words.push_back(want);
            end

            if (out_valid && out_ready) begin
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result word: lf=%0d lr=%0d rf=%0d rr=%0d st=%0d",
                                 left_forward, left_reverse, right_forward, right_reverse,
                                 status);
                end
                else begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (left_forward !== want.drive.left_forward ||
                        left_reverse !== want.drive.left_reverse ||
                        right_forward !== want.drive.right_forward ||
                        right_reverse !== want.drive.right_reverse ||
                        status !== want.status) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"result word %0d: expected lf=%0d lr=%0d rf=%0d rr=%0d ",
                                      "st=%0d, got lf=%0d lr=%0d rf=%0d rr=%0d st=%0d"},
                                     words_checked, want.drive.left_forward,
                                     want.drive.left_reverse, want.drive.right_forward,
                                     want.drive.right_reverse, want.status, left_forward,
                                     left_reverse, right_forward, right_reverse, status);
                    end
                end
            end

            pending_words = expected_words.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
// Testbench top for color_gated_line_follower_unit: clock, reset, sensor and settings
// stimulus, result-side stalls, watchdog and verdict. Depends on cglf_pkg and
// cglf_follow_checker.
module tb;
    import cglf_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int LONG_HOLD     = 120;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASE_ITEMS   = 104;
    localparam int PULSE_MAX     = (1 << PULSE_BITS) - 1;
    // straight, turn, white limit, green margin, red limit, runs, stop ms, resume ms
    localparam cfg_t POWER_UP = {8'd160, 8'd150, 16'd25, 16'd35, 16'd35, 3'd3,
                                 16'd5000, 16'd3000};

    typedef enum int { HUE_WHITE, HUE_GREEN, HUE_RED, HUE_UNKNOWN, HUE_NOISE } hue_kind_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    pulse_t      red_width;
    pulse_t      green_width;
    pulse_t      blue_width;
    logic [3:0]  line_bits;
    logic [31:0] now_ms;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  left_forward;
    logic [7:0]  left_reverse;
    logic [7:0]  right_forward;
    logic [7:0]  right_reverse;
    logic [2:0]  status;

    int          mismatch_count;
    int          pending_words;
    int          words_checked;

    cfg_t        shaping;       // settings as last loaded, used to aim the stimulus
    logic [31:0] clock_ms;
    logic        allow_stall;
    logic        hold_results;
    int          red_left;
    int          words_sent;
    int          loads_done;
    int          quiet;

    color_gated_line_follower_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .red_width     (red_width),
        .green_width   (green_width),
        .blue_width    (blue_width),
        .line_bits     (line_bits),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .left_forward  (left_forward),
        .left_reverse  (left_reverse),
        .right_forward (right_forward),
        .right_reverse (right_reverse),
        .status        (status)
    );

    cglf_follow_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .red_width      (red_width),
        .green_width    (green_width),
        .blue_width     (blue_width),
        .line_bits      (line_bits),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_forward   (left_forward),
        .left_reverse   (left_reverse),
        .right_forward  (right_forward),
        .right_reverse  (right_reverse),
        .status         (status),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words),
        .words_checked  (words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT) begin
                $display("color_gated_line_follower_unit regression: fail");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    // result side: ready with random stall bursts, plus one long hold on request
    initial
    begin : result_sink
        int gap;
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_results) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_results = 1'b0;
            end
            else if (allow_stall && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 19);
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_word(
        input pulse_t      r,
        input pulse_t      g,
        input pulse_t      b,
        input logic [3:0]  bits,
        input logic [31:0] now
    );
        int gap;
        if (allow_stall && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        red_width <= r;
        green_width <= g;
        blue_width <= b;
        line_bits <= bits;
        now_ms <= now;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // stop offering, let every outstanding result word come back, then settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_words == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // cfg_valid stays up across back-to-back writes; the caller lowers it
    task automatic write_setting(input cfg_index_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_settings(input cfg_t s, input logic garble);
        logic [15:0] junk;
        junk = garble ? 16'($urandom) : 16'd0;
        wait_drained();
        write_setting(CFG_STRAIGHT_SPEED, {junk[15:8], s.straight_speed});
        write_setting(CFG_TURN_SPEED, {junk[7:0], s.turn_speed});
        write_setting(CFG_WHITE_LIMIT, s.white_limit);
        write_setting(CFG_GREEN_MARGIN, s.green_margin);
        write_setting(CFG_RED_LIMIT, s.red_limit);
        write_setting(CFG_RED_RUNS, {junk[12:0], s.red_runs_needed});
        write_setting(CFG_STOP_MS, s.stop_ms);
        write_setting(CFG_RESUME_MS, s.resume_ms);
        cfg_valid <= 1'b0;
        shaping = s;
        loads_done++;
    endtask

    function automatic cfg_t random_settings();
        cfg_t s;
        s.straight_speed  = 8'($urandom_range(0, 255));
        s.turn_speed      = 8'($urandom_range(0, 255));
        s.white_limit     = 16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 300));
        s.green_margin    = 16'($urandom_range(0, 65535));
        s.red_limit       = 16'($urandom_range(0, 2000));
        s.red_runs_needed = 3'($urandom_range(0, 7));
        s.stop_ms         = 16'($urandom_range(0, 200));
        s.resume_ms       = 16'($urandom_range(0, 200));
        return s;
    endfunction

    // widths that land in the wanted color class under the current settings
    task automatic make_widths(input hue_kind_t hue, output pulse_t r, output pulse_t g,
                               output pulse_t b);
        int rv;
        int gv;
        int bv;
        int floor_v;
        int wl;
        wl = int'(shaping.white_limit);
        if (hue == HUE_RED && shaping.red_limit == 16'd0)
            hue = HUE_NOISE;
        case (hue)
            HUE_WHITE: begin
                rv = $urandom_range(0, wl);
                gv = $urandom_range(0, wl);
                bv = $urandom_range(0, wl);
            end
            HUE_GREEN: begin
                gv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200000)
                                                 : $urandom_range(0, 3000);
                floor_v = (gv > wl) ? gv + 1 : wl + 1;
                rv = floor_v + $urandom_range(0, 5000);
                // blue below green counts as within the margin
                bv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, gv)
                                                 : gv + $urandom_range(0, shaping.green_margin);
            end
            HUE_RED: begin
                rv = $urandom_range(0, shaping.red_limit - 1);
                gv = rv + $urandom_range(0, 1000);
                floor_v = (rv > wl) ? rv + 1 : wl + 1;
                bv = floor_v + $urandom_range(0, 1000);
            end
            HUE_UNKNOWN: begin
                rv = ((shaping.red_limit > wl) ? shaping.red_limit : wl + 1)
                     + $urandom_range(0, 1000);
                gv = rv + $urandom_range(0, 1000);
                bv = $urandom_range(0, PULSE_MAX);
            end
            default: begin
                rv = $urandom_range(0, PULSE_MAX);
                gv = $urandom_range(0, PULSE_MAX);
                bv = $urandom_range(0, PULSE_MAX);
            end
        endcase
        r = rv[PULSE_BITS-1:0];
        g = gv[PULSE_BITS-1:0];
        b = bv[PULSE_BITS-1:0];
    endtask

    // ms steps sized so stop and resume phases last a handful of words
    task automatic next_time();
        int span;
        span = ((shaping.stop_ms > shaping.resume_ms) ? shaping.stop_ms : shaping.resume_ms)
               / 4 + 2;
        case ($urandom_range(0, 19))
            0: ;
            1: clock_ms = clock_ms + $urandom();
            default: clock_ms = clock_ms + $urandom_range(1, span);
        endcase
    endtask

    task automatic run_traffic(input int count, input logic stalls, input logic hold_midway,
                               input logic drain_midway);
        hue_kind_t   hue;
        pulse_t      r;
        pulse_t      g;
        pulse_t      b;
        logic [3:0]  bits;
        int          pick;
        for (int n = 0; n < count; n++) begin
            if (n % 20 == 0)
                allow_stall = stalls && ($urandom_range(0, 2) != 0);
            if (hold_midway && n == count / 3)
                hold_results = 1'b1;
            if (drain_midway && n == count / 2)
                wait_drained();
            if (red_left > 0) begin
                hue = HUE_RED;
                red_left--;
            end
            else begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    hue = HUE_NOISE;
                else if (pick < 18)
                    hue = HUE_UNKNOWN;
                else if (pick < 42)
                    hue = HUE_WHITE;
                else if (pick < 70)
                    hue = HUE_GREEN;
                else begin
                    hue = HUE_RED;
                    red_left = $urandom_range(0, 7);
                end
            end
            make_widths(hue, r, g, b);
            next_time();
            bits = 4'($urandom_range(0, 15));
            send_word(r, g, b, bits, clock_ms);
        end
        allow_stall = 1'b0;
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        red_width = '0;
        green_width = '0;
        blue_width = '0;
        line_bits = '0;
        now_ms = '0;
        hold_results = 1'b0;
        allow_stall = 1'b0;
        red_left = 0;
        words_sent = 0;
        loads_done = 0;
        quiet = 0;
        shaping = POWER_UP;
        clock_ms = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words on power-up settings
        send_word(20'd0, 20'd0, 20'd0, 4'b0000, 32'd0);                 // white, parked
        send_word(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 4'b1111, 32'hFFFF_FFFF);
        send_word(20'd100, 20'd50, 20'd85, 4'b0000, 32'd10);            // green at margin
        send_word(20'd100, 20'd50, 20'd85, 4'b1100, 32'd20);
        send_word(20'd100, 20'd50, 20'd85, 4'b0001, 32'd30);
        send_word(20'd100, 20'd50, 20'd85, 4'b0010, 32'd40);
        send_word(20'd100, 20'd50, 20'd85, 4'b0100, 32'd50);
        send_word(20'd100, 20'd50, 20'd85, 4'b1000, 32'd60);
        send_word(20'd25, 20'd25, 20'd25, 4'b0011, 32'd70);             // white at limit
        send_word(20'd100, 20'd50, 20'd86, 4'b0101, 32'd80);            // one past margin
        send_word(20'd10, 20'd10, 20'd40, 4'b0110, 32'd1000);           // red run
        send_word(20'd10, 20'd10, 20'd40, 4'b0110, 32'd1001);
        send_word(20'd10, 20'd10, 20'd40, 4'b0110, 32'd1002);
        send_word(20'd0, 20'd0, 20'd0, 4'b1111, 32'd6001);              // last stopped ms
        send_word(20'd0, 20'd0, 20'd0, 4'b0100, 32'd6002);              // resume begins
        send_word(20'd0, 20'd0, 20'd0, 4'b1000, 32'd9001);
        send_word(20'd0, 20'd0, 20'd0, 4'b0000, 32'd9002);              // resume over
        send_word(20'd34, 20'd34, 20'd35, 4'b0000, 32'd9003);
        send_word(20'd35, 20'd35, 20'd100, 4'b0000, 32'd9004);          // red width at the limit, not red
        send_word(20'd100, 20'd50, 20'd50, 4'b0000, 32'hFFFF_F000);
        send_word(20'd10, 20'd10, 20'd40, 4'b0010, 32'hFFFF_F001);      // stop across wrap
        send_word(20'd10, 20'd10, 20'd40, 4'b0010, 32'hFFFF_F002);
        send_word(20'd10, 20'd10, 20'd40, 4'b0010, 32'hFFFF_F003);
        send_word(20'd10, 20'd10, 20'd40, 4'b0001, 32'h0000_438B);
        send_word(20'd0, 20'd0, 20'd0, 4'b0000, 32'h0000_438A);         // ms steps back

        load_settings({8'd200, 8'd90, 16'd25, 16'd35, 16'd400, 3'd2, 16'd30, 16'd20}, 1'b0);
        run_traffic(PHASE_ITEMS, 1'b1, 1'b1, 1'b0);

        // zero run count, zero stop and resume, zero speeds
        load_settings({8'd0, 8'd0, 16'd0, 16'd0, 16'hFFFF, 3'd0, 16'd0, 16'd0}, 1'b0);
        run_traffic(PHASE_ITEMS, 1'b1, 1'b0, 1'b1);

        load_settings({8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF,
                       16'hFFFF}, 1'b0);
        run_traffic(PHASE_ITEMS, 1'b1, 1'b0, 1'b0);

        // straight speed just under the right offset, red unreachable
        load_settings({8'd39, 8'd200, 16'd40, 16'd10, 16'd0, 3'd1, 16'd1, 16'd1}, 1'b0);
        run_traffic(PHASE_ITEMS, 1'b1, 1'b0, 1'b1);

        load_settings({8'd40, 8'd120, 16'd60, 16'd500, 16'd1, 3'd1, 16'd2, 16'd1}, 1'b0);
        clock_ms = 32'hFFFF_FF00;
        run_traffic(PHASE_ITEMS, 1'b1, 1'b1, 1'b0);

        load_settings(random_settings(), 1'b1);
        run_traffic(PHASE_ITEMS, 1'b1, 1'b0, 1'b0);

        load_settings(random_settings(), 1'b1);
        run_traffic(PHASE_ITEMS, 1'b1, 1'b0, 1'b1);

        // closing stretch runs flat out on both sides
        load_settings(random_settings(), 1'b1);
        run_traffic(PHASE_ITEMS, 1'b0, 1'b0, 1'b0);

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_words == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Drove %0d sensor words through %0d settings loads, %0d result words checked.",
                 words_sent, loads_done, words_checked);
        $display("Hit red stops, resumes, ms wrap, zero-length phases and output back-pressure.");
        if (mismatch_count == 0 && pending_words == 0)
            $display("color_gated_line_follower_unit regression: pass");
        else
            $display("color_gated_line_follower_unit regression: fail");
        $finish;
    end

endmodule
